### src/lsfe_pkg.sv
// shared types, constants and helper functions of the led strip frame engine
package lsfe_pkg;

  localparam int PIXELS     = 32;
  localparam int IDX_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int FRAME_AW   = IDX_W + 1;
  localparam int FRAME_DEPTH = 2 ** FRAME_AW;

  localparam logic [3:0] FN_TICK        = 4'd0;
  localparam logic [3:0] FN_START_INPUT = 4'd1;
  localparam logic [3:0] FN_FINALIZE    = 4'd2;
  localparam logic [3:0] FN_BRIGHT_UP   = 4'd3;
  localparam logic [3:0] FN_BRIGHT_DOWN = 4'd4;
  localparam logic [3:0] FN_FASTER      = 4'd5;
  localparam logic [3:0] FN_SLOWER      = 4'd6;
  localparam logic [3:0] FN_SET_PIXEL   = 4'd7;
  localparam logic [3:0] FN_FILL        = 4'd8;
  localparam logic [3:0] FN_LOAD_BRIGHT = 4'd9;
  localparam logic [3:0] FN_LOAD_DIV    = 4'd10;
  localparam logic [3:0] FN_REDRAW      = 4'd11;

  localparam logic [1:0] MODE_BUFFERED = 2'd0;
  localparam logic [1:0] MODE_RANDOM   = 2'd1;
  localparam logic [1:0] MODE_ROTATE   = 2'd2;

  localparam logic [1:0] CFG_MAX_BRIGHT = 2'd0;
  localparam logic [1:0] CFG_ENABLE     = 2'd1;
  localparam logic [1:0] CFG_MODE       = 2'd2;

  localparam logic [8:0]  BRIGHT_FULL  = 9'd256;
  localparam logic [8:0]  BRIGHT_RESET = 9'd64;
  localparam logic [8:0]  BRIGHT_STEP  = 9'd13;
  localparam logic [7:0]  DIV_MAX      = 8'hff;
  localparam logic [31:0] LFSR_MASK    = 32'ha300_0000;
  localparam logic [31:0] LFSR_SEED    = 32'h0000_0001;
  localparam logic [23:0] WORD_MOD     = 24'hff_ffff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RFILL,
    S_PRIME,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start_fill;
    logic start_rfill;
    logic start_emit;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    logic             busy;
    logic             fill_we;
    logic             rfill_we;
    logic             rd_en;
    logic             load_out;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_idx;
  } seq_ctrl_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] x);
    logic [31:0] y;
    y = x >> 1;
    if (x[0]) begin
      y = y ^ LFSR_MASK;
    end
    return y;
  endfunction

  // 2^24 is 1 modulo 2^24-1, so fold the top byte and subtract once
  function automatic logic [23:0] mod_word(input logic [31:0] x);
    logic [24:0] s;
    s = {1'b0, x[23:0]} + {17'd0, x[31:24]};
    if (s >= {1'b0, WORD_MOD}) begin
      s = s - {1'b0, WORD_MOD};
    end
    return s[23:0];
  endfunction

endpackage

### src/lsfe_in_if.sv
// input channel: event code and edit payload
interface lsfe_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [8:0] load_value;

  modport source(output valid, func, pixel_index, red, green, blue, load_value,
                 input ready);
  modport sink(input valid, func, pixel_index, red, green, blue, load_value,
               output ready);
endinterface

### src/lsfe_out_if.sv
// result channel: scaled pixel words
interface lsfe_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_word;
  logic        last_pixel;

  modport source(output valid, pixel_word, last_pixel, input ready);
  modport sink(input valid, pixel_word, last_pixel, output ready);
endinterface

### src/led_strip_frame_engine.sv
// led strip frame engine: event decode, frame and pattern stores, output register
// a tick that emits a frame primes the store reads and then sends the words out, first
// generating the rotating pattern if it has not been generated yet
// a fill sweeps every pixel of the back half; the block takes no event while it is busy
// one read port per store and the scaler: a pixel word per cycle unless output stalls
// rst_n is synchronous, active low; the frame store reads as zero through valid bits
module led_strip_frame_engine (
  input  logic        clk,
  input  logic        rst_n,
  lsfe_in_if.sink     in_ch,
  lsfe_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  lsfe_pkg::seq_status_t status;
  lsfe_pkg::seq_ctrl_t   ctrl;

  logic [8:0]  max_r;
  logic        en_r;
  logic [1:0]  mode_r;

  logic        front_r, front_nxt;
  logic        dirty_r, dirty_nxt;
  logic        redraw_r, redraw_nxt;
  logic [8:0]  bright_r, bright_nxt;
  logic [7:0]  div_r, div_nxt;
  logic [7:0]  tcount_r, tcount_nxt;
  logic        rfilled_r, rfilled_nxt;
  logic [lsfe_pkg::IDX_W-1:0] offset_r, offset_nxt;
  logic [31:0] lfsr_r, lfsr_nxt;

  logic [lsfe_pkg::FRAME_DEPTH-1:0] frame_vld_r;
  logic [23:0] frame_mem [lsfe_pkg::FRAME_DEPTH];
  logic [23:0] rot_mem [lsfe_pkg::PIXELS];
  logic [23:0] frame_rd_r;
  logic        frame_hit_r;
  logic [23:0] rot_rd_r;
  logic [23:0] fill_color_r;

  logic        out_valid_r;
  logic [23:0] out_word_r;
  logic        out_last_r;

  logic        in_fire;
  logic        is_rand;
  logic        is_rot;
  logic        is_buf;
  logic [8:0]  lim;
  logic [9:0]  bright_up;
  logic        tick_emit;
  logic        set_we;
  logic        frame_we;
  logic [lsfe_pkg::FRAME_AW-1:0] frame_waddr;
  logic [lsfe_pkg::FRAME_AW-1:0] frame_raddr;
  logic [23:0] color;
  logic [lsfe_pkg::IDX_W:0]   rot_sum;
  logic [lsfe_pkg::IDX_W-1:0] rot_raddr;
  logic [31:0] lfsr_adv;
  logic [23:0] src_word;
  logic [23:0] scaled_word;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !ctrl.busy;

  assign is_rand = (mode_r == lsfe_pkg::MODE_RANDOM);
  assign is_rot  = (mode_r == lsfe_pkg::MODE_ROTATE);
  assign is_buf  = !is_rand && !is_rot;
  assign lim     = (max_r > lsfe_pkg::BRIGHT_FULL) ? lsfe_pkg::BRIGHT_FULL : max_r;
  assign color   = {in_ch.green, in_ch.red, in_ch.blue};
  assign lfsr_adv = lsfe_pkg::lfsr_step(lfsr_r);
  assign bright_up = {1'b0, bright_r} + {1'b0, lsfe_pkg::BRIGHT_STEP};

  assign tick_emit = in_fire && (in_ch.func == lsfe_pkg::FN_TICK) && redraw_r
                     && !(tcount_r < div_r);

  assign status.start_fill  = in_fire && (in_ch.func == lsfe_pkg::FN_FILL) && en_r && is_buf;
  assign status.start_rfill = tick_emit && is_rot && en_r && !rfilled_r;
  assign status.start_emit  = tick_emit && !(is_rot && en_r && !rfilled_r);
  assign status.out_free    = !out_valid_r || out_ch.ready;

  lsfe_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= lsfe_pkg::BRIGHT_FULL;
      en_r   <= 1'b1;
      mode_r <= lsfe_pkg::MODE_ROTATE;
    end else if (cfg_we) begin
      case (cfg_index)
        lsfe_pkg::CFG_MAX_BRIGHT: max_r  <= cfg_wdata;
        lsfe_pkg::CFG_ENABLE:     en_r   <= cfg_wdata[0];
        lsfe_pkg::CFG_MODE:       mode_r <= cfg_wdata[1:0];
        default:                  max_r  <= max_r;
      endcase
    end
  end

  // event decode
  always_comb begin
    front_nxt   = front_r;
    dirty_nxt   = dirty_r;
    redraw_nxt  = redraw_r;
    bright_nxt  = bright_r;
    div_nxt     = div_r;
    tcount_nxt  = tcount_r;
    rfilled_nxt = rfilled_r;
    offset_nxt  = offset_r;
    lfsr_nxt    = lfsr_r;
    set_we      = 1'b0;
    if (in_fire) begin
      case (in_ch.func)
        lsfe_pkg::FN_TICK: begin
          if (redraw_r) begin
            if (tcount_r < div_r) begin
              tcount_nxt = tcount_r + 1'b1;
            end else begin
              tcount_nxt = '0;
              redraw_nxt = 1'b0;
              if (status.start_rfill) begin
                rfilled_nxt = 1'b1;
              end
            end
          end
        end
        lsfe_pkg::FN_START_INPUT: begin
          if (!is_buf && en_r) begin
            redraw_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_FINALIZE: begin
          if (is_buf && dirty_r && en_r) begin
            front_nxt  = !front_r;
            dirty_nxt  = 1'b0;
            redraw_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_BRIGHT_UP: begin
          if (en_r) begin
            bright_nxt = (bright_up > {1'b0, lim}) ? lim : bright_up[8:0];
            redraw_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_BRIGHT_DOWN: begin
          if (en_r) begin
            bright_nxt = (bright_r < lsfe_pkg::BRIGHT_STEP) ? 9'd0
                         : bright_r - lsfe_pkg::BRIGHT_STEP;
            redraw_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_FASTER: begin
          if (en_r) begin
            if (div_r > 8'd1) begin
              div_nxt = div_r - 1'b1;
            end
            redraw_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_SLOWER: begin
          if (en_r) begin
            if (div_r < lsfe_pkg::DIV_MAX) begin
              div_nxt = div_r + 1'b1;
            end
            redraw_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_SET_PIXEL: begin
          if (en_r && is_buf && ({1'b0, in_ch.pixel_index} < 7'(lsfe_pkg::PIXELS))) begin
            set_we    = 1'b1;
            dirty_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_FILL: begin
          if (status.start_fill) begin
            dirty_nxt = 1'b1;
          end
        end
        lsfe_pkg::FN_LOAD_BRIGHT: begin
          bright_nxt = (in_ch.load_value > lim) ? lim : in_ch.load_value;
        end
        lsfe_pkg::FN_LOAD_DIV: begin
          div_nxt    = (in_ch.load_value > {1'b0, lsfe_pkg::DIV_MAX}) ? lsfe_pkg::DIV_MAX
                       : in_ch.load_value[7:0];
          tcount_nxt = '0;
        end
        lsfe_pkg::FN_REDRAW: begin
          redraw_nxt = 1'b1;
        end
        default: begin
          redraw_nxt = redraw_r;
        end
      endcase
    end
    if (ctrl.rfill_we || (ctrl.load_out && en_r && is_rand)) begin
      lfsr_nxt = lfsr_adv;
    end
    if (ctrl.load_out && ctrl.last && en_r && is_rot) begin
      offset_nxt = (offset_r == lsfe_pkg::IDX_W'(lsfe_pkg::PIXELS - 1)) ? '0
                   : offset_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= 1'b0;
      dirty_r   <= 1'b0;
      redraw_r  <= 1'b0;
      bright_r  <= lsfe_pkg::BRIGHT_RESET;
      div_r     <= '0;
      tcount_r  <= '0;
      rfilled_r <= 1'b0;
      offset_r  <= '0;
      lfsr_r    <= lsfe_pkg::LFSR_SEED;
    end else begin
      front_r   <= front_nxt;
      dirty_r   <= dirty_nxt;
      redraw_r  <= redraw_nxt;
      bright_r  <= bright_nxt;
      div_r     <= div_nxt;
      tcount_r  <= tcount_nxt;
      rfilled_r <= rfilled_nxt;
      offset_r  <= offset_nxt;
      lfsr_r    <= lfsr_nxt;
    end
  end

  // fill colour held for the whole sweep
  always_ff @(posedge clk) begin
    if (status.start_fill) begin
      fill_color_r <= color;
    end
  end

  // frame store, two halves
  assign frame_we    = set_we || ctrl.fill_we;
  assign frame_waddr = set_we ? {!front_r, in_ch.pixel_index[lsfe_pkg::IDX_W-1:0]}
                              : {!front_r, ctrl.idx};
  assign frame_raddr = {front_r, ctrl.rd_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= '0;
    end else if (frame_we) begin
      frame_vld_r[frame_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= set_we ? color : fill_color_r;
    end
    if (ctrl.rd_en) begin
      frame_rd_r  <= frame_mem[frame_raddr];
      frame_hit_r <= frame_vld_r[frame_raddr];
    end
  end

  // rotating pattern store
  assign rot_sum   = {1'b0, ctrl.rd_idx} + {1'b0, offset_r};
  assign rot_raddr = (rot_sum >= (lsfe_pkg::IDX_W + 1)'(lsfe_pkg::PIXELS))
                     ? lsfe_pkg::IDX_W'(rot_sum - (lsfe_pkg::IDX_W + 1)'(lsfe_pkg::PIXELS))
                     : rot_sum[lsfe_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.rfill_we) begin
      rot_mem[ctrl.idx] <= lsfe_pkg::mod_word(lfsr_adv);
    end
    if (ctrl.rd_en) begin
      rot_rd_r <= rot_mem[rot_raddr];
    end
  end

  // word source and scaling
  always_comb begin
    src_word = '0;
    if (en_r) begin
      if (is_rand) begin
        src_word = lfsr_adv[23:0];
      end else if (is_rot) begin
        src_word = rot_rd_r;
      end else if (frame_hit_r) begin
        src_word = frame_rd_r;
      end
    end
  end

  lsfe_scaler u_scaler (
    .word_in  (src_word),
    .level    (bright_r),
    .word_out (scaled_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_word_r <= scaled_word;
      out_last_r <= ctrl.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_word = out_word_r;
  assign out_ch.last_pixel = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten before transfer");

  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.load_out && ctrl.last) |=> in_ch.ready)
    else $error("block not ready after last word of frame");

  a_rfill_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rfill_we |=> rfilled_r)
    else $error("pattern generated without filled flag");

  a_bright_max: assert property (@(posedge clk) disable iff (!rst_n)
    bright_r <= lsfe_pkg::BRIGHT_FULL)
    else $error("brightness above full scale");

endmodule

### src/lsfe_scaler.sv
// shared brightness scaler, one grb word per cycle
module lsfe_scaler (
  input  logic [23:0] word_in,
  input  logic [8:0]  level,
  output logic [23:0] word_out
);

  logic [8:0]  k;
  logic [16:0] prod_g;
  logic [16:0] prod_r;
  logic [16:0] prod_b;

  assign k      = (level > lsfe_pkg::BRIGHT_FULL) ? lsfe_pkg::BRIGHT_FULL : level;
  assign prod_g = {9'd0, word_in[23:16]} * {8'd0, k};
  assign prod_r = {9'd0, word_in[15:8]} * {8'd0, k};
  assign prod_b = {9'd0, word_in[7:0]} * {8'd0, k};

  assign word_out = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};

endmodule

### src/lsfe_seq.sv
// sequencer for fill sweeps, pattern fill and frame emission
module lsfe_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsfe_pkg::seq_status_t status,
  output lsfe_pkg::seq_ctrl_t   ctrl
);

  lsfe_pkg::state_t             state_r;
  lsfe_pkg::state_t             state_nxt;
  logic [lsfe_pkg::IDX_W-1:0]   cnt_r;
  logic [lsfe_pkg::IDX_W-1:0]   cnt_nxt;
  logic                         cnt_last;

  assign cnt_last = (cnt_r == lsfe_pkg::IDX_W'(lsfe_pkg::PIXELS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsfe_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      lsfe_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (status.start_fill) begin
          state_nxt = lsfe_pkg::S_FILL;
        end else if (status.start_rfill) begin
          state_nxt = lsfe_pkg::S_RFILL;
        end else if (status.start_emit) begin
          state_nxt = lsfe_pkg::S_PRIME;
        end
      end
      lsfe_pkg::S_FILL: begin
        if (cnt_last) begin
          state_nxt = lsfe_pkg::S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lsfe_pkg::S_RFILL: begin
        if (cnt_last) begin
          state_nxt = lsfe_pkg::S_PRIME;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lsfe_pkg::S_PRIME: begin
        state_nxt = lsfe_pkg::S_EMIT;
      end
      lsfe_pkg::S_EMIT: begin
        if (status.out_free) begin
          if (cnt_last) begin
            state_nxt = lsfe_pkg::S_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lsfe_pkg::S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.busy     = (state_r != lsfe_pkg::S_IDLE);
    ctrl.idx      = cnt_r;
    ctrl.rd_idx   = cnt_r;
    ctrl.last     = cnt_last;
    case (state_r)
      lsfe_pkg::S_FILL: begin
        ctrl.fill_we = 1'b1;
      end
      lsfe_pkg::S_RFILL: begin
        ctrl.rfill_we = 1'b1;
      end
      lsfe_pkg::S_PRIME: begin
        ctrl.rd_en = 1'b1;
      end
      lsfe_pkg::S_EMIT: begin
        // prefetch the next word while the current one goes out
        ctrl.load_out = status.out_free;
        ctrl.rd_en    = status.out_free && !cnt_last;
        ctrl.rd_idx   = cnt_r + 1'b1;
      end
      default: begin
        ctrl.busy = ctrl.busy;
      end
    endcase
  end

endmodule

### verif/led_strip_frame_engine_tb.sv
// testbench of the led strip frame engine: directed and random events, frame words checked
module led_strip_frame_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] FN_SPARE = 4'd12;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CFG_SETTLE = 100;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 36;

  typedef struct packed {
    logic [3:0]  func;
    logic [5:0]  idx;
    logic [23:0] grb;
    logic [8:0]  load;
  } strip_event_t;

  typedef struct packed {
    logic [23:0] word;
    logic        last;
  } pixel_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = lsfe_pkg::CFG_MAX_BRIGHT;
  logic [8:0] cfg_wdata = '0;

  lsfe_in_if  in_ch();
  lsfe_out_if out_ch();

  led_strip_frame_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [8:0]  lim_reg;
  logic        strip_on;
  logic [1:0]  anim_mode;
  logic [23:0] frame_mem [2][lsfe_pkg::PIXELS];
  logic        front_sel;
  logic        back_dirty;
  logic        redraw;
  int          bright;
  logic [7:0]  tick_div;
  logic [7:0]  tick_cnt;
  logic [23:0] pattern_mem [lsfe_pkg::PIXELS];
  logic        pattern_ready;
  int          pattern_off;
  logic [31:0] lfsr;

  strip_event_t stim_q[$];
  pixel_word_t  words_due[$];
  int           errors = 0;
  logic         in_took = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           hold_cnt = 0;
  int           hold_kicks = 0;
  int           hold_seen = 0;
  logic         quiet = 1'b0;

  always #5 clk = ~clk;

  function automatic void model_reset();
    int i;
    lim_reg = lsfe_pkg::BRIGHT_FULL;
    strip_on = 1'b1;
    anim_mode = lsfe_pkg::MODE_ROTATE;
    for (i = 0; i < lsfe_pkg::PIXELS; i++) begin
      frame_mem[0][i] = '0;
      frame_mem[1][i] = '0;
      pattern_mem[i] = '0;
    end
    front_sel = 1'b0;
    back_dirty = 1'b0;
    redraw = 1'b0;
    bright = 64;
    tick_div = '0;
    tick_cnt = '0;
    pattern_ready = 1'b0;
    pattern_off = 0;
    lfsr = 32'd1;
  endfunction

  function automatic logic [31:0] lfsr_advance();
    lfsr = lfsr[0] ? ((lfsr >> 1) ^ lsfe_pkg::LFSR_MASK) : (lfsr >> 1);
    return lfsr;
  endfunction

  function automatic logic [23:0] scale_grb(input logic [23:0] c);
    int k;
    logic [23:0] s;
    k = (bright > 256) ? 256 : bright;
    s[23:16] = 8'((int'(c[23:16]) * k) >> 8);
    s[15:8]  = 8'((int'(c[15:8]) * k) >> 8);
    s[7:0]   = 8'((int'(c[7:0]) * k) >> 8);
    return s;
  endfunction

  function automatic void apply_event(input strip_event_t ev);
    int          lim;
    int          i;
    logic [1:0]  md;
    logic [23:0] w;
    logic [31:0] r;
    pixel_word_t pw;
    lim = (lim_reg > lsfe_pkg::BRIGHT_FULL) ? 256 : int'(lim_reg);
    md = (anim_mode == MODE_SPARE) ? lsfe_pkg::MODE_BUFFERED : anim_mode;
    case (ev.func)
      lsfe_pkg::FN_TICK: begin
        if (redraw) begin
          if (tick_cnt < tick_div) begin
            tick_cnt = tick_cnt + 8'd1;
          end else begin
            tick_cnt = '0;
            redraw = 1'b0;
            if (md == lsfe_pkg::MODE_ROTATE && strip_on && !pattern_ready) begin
              for (i = 0; i < lsfe_pkg::PIXELS; i++) begin
                pattern_mem[i] = 24'(lfsr_advance() % 32'h00ff_ffff);
              end
              pattern_ready = 1'b1;
            end
            for (i = 0; i < lsfe_pkg::PIXELS; i++) begin
              w = '0;
              if (strip_on) begin
                if (md == lsfe_pkg::MODE_BUFFERED) begin
                  w = scale_grb(frame_mem[front_sel][i]);
                end else if (md == lsfe_pkg::MODE_RANDOM) begin
                  r = lfsr_advance();
                  w = scale_grb(r[23:0]);
                end else begin
                  w = scale_grb(pattern_mem[(i + pattern_off) % lsfe_pkg::PIXELS]);
                end
              end
              pw.word = w;
              pw.last = (i == lsfe_pkg::PIXELS - 1);
              words_due.insert(words_due.size(), pw);
            end
            if (strip_on && md == lsfe_pkg::MODE_ROTATE) begin
              pattern_off = (pattern_off + 1) % lsfe_pkg::PIXELS;
            end
          end
        end
      end
      lsfe_pkg::FN_START_INPUT: begin
        if (md != lsfe_pkg::MODE_BUFFERED && strip_on) redraw = 1'b1;
      end
      lsfe_pkg::FN_FINALIZE: begin
        if (md == lsfe_pkg::MODE_BUFFERED && back_dirty && strip_on) begin
          front_sel = ~front_sel;
          back_dirty = 1'b0;
          redraw = 1'b1;
        end
      end
      lsfe_pkg::FN_BRIGHT_UP: begin
        if (strip_on) begin
          bright = bright + int'(lsfe_pkg::BRIGHT_STEP);
          if (bright > lim) bright = lim;
          redraw = 1'b1;
        end
      end
      lsfe_pkg::FN_BRIGHT_DOWN: begin
        if (strip_on) begin
          bright = (bright < int'(lsfe_pkg::BRIGHT_STEP)) ? 0
                   : bright - int'(lsfe_pkg::BRIGHT_STEP);
          redraw = 1'b1;
        end
      end
      lsfe_pkg::FN_FASTER: begin
        if (strip_on) begin
          if (tick_div > 8'd1) tick_div = tick_div - 8'd1;
          redraw = 1'b1;
        end
      end
      lsfe_pkg::FN_SLOWER: begin
        if (strip_on) begin
          if (tick_div < lsfe_pkg::DIV_MAX) tick_div = tick_div + 8'd1;
          redraw = 1'b1;
        end
      end
      lsfe_pkg::FN_SET_PIXEL: begin
        if (strip_on && md == lsfe_pkg::MODE_BUFFERED && ev.idx < lsfe_pkg::PIXELS) begin
          frame_mem[~front_sel][ev.idx] = ev.grb;
          back_dirty = 1'b1;
        end
      end
      lsfe_pkg::FN_FILL: begin
        if (strip_on && md == lsfe_pkg::MODE_BUFFERED) begin
          for (i = 0; i < lsfe_pkg::PIXELS; i++) frame_mem[~front_sel][i] = ev.grb;
          back_dirty = 1'b1;
        end
      end
      lsfe_pkg::FN_LOAD_BRIGHT: begin
        bright = (int'(ev.load) > lim) ? lim : int'(ev.load);
      end
      lsfe_pkg::FN_LOAD_DIV: begin
        tick_div = (ev.load > 9'd255) ? lsfe_pkg::DIV_MAX : ev.load[7:0];
        tick_cnt = '0;
      end
      lsfe_pkg::FN_REDRAW: begin
        redraw = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // result check and prediction on each transfer
  always @(posedge clk) begin
    pixel_word_t exp_w;
    strip_event_t ev;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected pixel word %06h last %0b", out_ch.pixel_word, out_ch.last_pixel);
        end
      end else begin
        exp_w = words_due.pop_front();
        if (out_ch.pixel_word !== exp_w.word || out_ch.last_pixel !== exp_w.last) begin
          errors++;
          if (errors <= 10) begin
            $display("pixel word mismatch: exp %06h last %0b, got %06h last %0b",
                     exp_w.word, exp_w.last, out_ch.pixel_word, out_ch.last_pixel);
          end
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      ev.func = in_ch.func;
      ev.idx = in_ch.pixel_index;
      ev.grb = {in_ch.green, in_ch.red, in_ch.blue};
      ev.load = in_ch.load_value;
      apply_event(ev);
    end
  end

  // event driver
  always @(negedge clk) begin
    strip_event_t ev;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= lsfe_pkg::FN_TICK;
      in_ch.pixel_index <= '0;
      in_ch.red <= '0;
      in_ch.green <= '0;
      in_ch.blue <= '0;
      in_ch.load_value <= '0;
    end else if (!in_ch.valid || in_took) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        ev = stim_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= ev.func;
        in_ch.pixel_index <= ev.idx;
        in_ch.green <= ev.grb[23:16];
        in_ch.red <= ev.grb[15:8];
        in_ch.blue <= ev.grb[7:0];
        in_ch.load_value <= ev.load;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_kicks != hold_seen) begin
      hold_seen = hold_kicks;
      hold_cnt = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap = out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 14);
    end
  end

  function automatic void queue_event(input logic [3:0] f, input logic [5:0] ix,
                                      input logic [23:0] grb, input logic [8:0] ld);
    strip_event_t ev;
    ev.func = f;
    ev.idx = ix;
    ev.grb = grb;
    ev.load = ld;
    stim_q.insert(stim_q.size(), ev);
  endfunction

  // edits, a redraw trigger and a run of ticks, sized from the divider when one is loaded
  function automatic int queue_frame_seq(input logic [1:0] md);
    int n;
    int d;
    int ticks;
    n = 0;
    d = -1;
    if ($urandom_range(0, 4) != 0) begin
      d = $urandom_range(0, 3);
      queue_event(lsfe_pkg::FN_LOAD_DIV, 6'($urandom), 24'($urandom), 9'(d));
      n++;
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_event(lsfe_pkg::FN_LOAD_BRIGHT, 6'($urandom), 24'($urandom),
                  9'($urandom_range(0, 511)));
      n++;
    end
    repeat ($urandom_range(0, 4)) begin
      queue_event(($urandom_range(0, 7) == 0) ? lsfe_pkg::FN_FILL : lsfe_pkg::FN_SET_PIXEL,
                  6'($urandom_range(0, 39)), 24'($urandom), 9'($urandom));
      n++;
    end
    case ($urandom_range(0, 5))
      0, 1: queue_event((md == lsfe_pkg::MODE_BUFFERED || md == MODE_SPARE)
                        ? lsfe_pkg::FN_FINALIZE : lsfe_pkg::FN_START_INPUT,
                        6'($urandom), 24'($urandom), 9'($urandom));
      2: queue_event(lsfe_pkg::FN_REDRAW, 6'($urandom), 24'($urandom), 9'($urandom));
      3: queue_event(lsfe_pkg::FN_BRIGHT_UP, 6'($urandom), 24'($urandom), 9'($urandom));
      4: queue_event(lsfe_pkg::FN_BRIGHT_DOWN, 6'($urandom), 24'($urandom), 9'($urandom));
      default: queue_event(($urandom_range(0, 1) == 0) ? lsfe_pkg::FN_FASTER
                           : lsfe_pkg::FN_SLOWER,
                           6'($urandom), 24'($urandom), 9'($urandom));
    endcase
    n++;
    ticks = ((d < 0) ? $urandom_range(1, 3) : d + 1) + $urandom_range(0, 1);
    repeat (ticks) queue_event(lsfe_pkg::FN_TICK, 6'($urandom), 24'($urandom), 9'($urandom));
    return n + ticks;
  endfunction

  task automatic settle();
    while (stim_q.size() != 0 || in_ch.valid || words_due.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] ix, input logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (ix)
      lsfe_pkg::CFG_MAX_BRIGHT: lim_reg = val;
      lsfe_pkg::CFG_ENABLE:     strip_on = val[0];
      lsfe_pkg::CFG_MODE:       anim_mode = val[1:0];
      default: begin
      end
    endcase
  endtask

  initial begin
    int   cnt;
    int   wait_cnt;
    logic [1:0] md;
    logic [8:0] mb;
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: rotating pattern, divider and brightness limits
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);
    queue_event(FN_SPARE, 6'd63, 24'hffffff, 9'd511);
    queue_event(lsfe_pkg::FN_START_INPUT, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_LOAD_BRIGHT, 6'd0, 24'h000000, 9'd511);
    queue_event(lsfe_pkg::FN_BRIGHT_UP, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_LOAD_DIV, 6'd0, 24'h000000, 9'd1);
    queue_event(lsfe_pkg::FN_FASTER, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_LOAD_DIV, 6'd0, 24'h000000, 9'd511);
    queue_event(lsfe_pkg::FN_SLOWER, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_LOAD_DIV, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_FASTER, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);
    settle();

    // spare mode code with a lowered limit, buffer edits and swap
    write_reg(lsfe_pkg::CFG_MODE, {7'd0, MODE_SPARE});
    write_reg(lsfe_pkg::CFG_MAX_BRIGHT, 9'd50);
    queue_event(lsfe_pkg::FN_BRIGHT_DOWN, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_FILL, 6'd0, 24'hffffff, 9'd0);
    queue_event(lsfe_pkg::FN_SET_PIXEL, 6'd63, 24'h5a5a5a, 9'd0);
    queue_event(lsfe_pkg::FN_SET_PIXEL, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_FINALIZE, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);
    settle();

    // strip disabled: edits ignored, forced redraw gives a black frame
    write_reg(lsfe_pkg::CFG_ENABLE, 9'd0);
    write_reg(lsfe_pkg::CFG_MODE, {7'd0, lsfe_pkg::MODE_RANDOM});
    write_reg(lsfe_pkg::CFG_MAX_BRIGHT, 9'd0);
    queue_event(lsfe_pkg::FN_BRIGHT_UP, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_FILL, 6'd0, 24'h123456, 9'd0);
    queue_event(lsfe_pkg::FN_START_INPUT, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_FINALIZE, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_REDRAW, 6'd0, 24'h000000, 9'd0);
    queue_event(lsfe_pkg::FN_TICK, 6'd0, 24'h000000, 9'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 3))
        0: mb = lsfe_pkg::BRIGHT_FULL;
        1: mb = 9'd511;
        2: mb = 9'($urandom_range(0, 511));
        default: mb = 9'd0;
      endcase
      md = 2'($urandom_range(0, 3));
      write_reg(lsfe_pkg::CFG_MAX_BRIGHT, mb);
      write_reg(lsfe_pkg::CFG_ENABLE, ($urandom_range(0, 5) != 0) ? 9'd1 : 9'd0);
      write_reg(lsfe_pkg::CFG_MODE, {7'd0, md});
      if (ph == 2) hold_kicks++;
      quiet = (ph == RANDOM_PHASES - 1);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_event(4'($urandom), 6'($urandom), 24'($urandom), 9'($urandom));
        end else begin
          cnt += queue_frame_seq(md);
        end
      end
    end

    while (stim_q.size() != 0 || in_ch.valid) @(posedge clk);
    wait_cnt = 0;
    while (words_due.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (CFG_SETTLE) @(posedge clk);
    errors += words_due.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
